// ===== hw/rtl/clpp_pkg.sv =====
// Package for the command line pipeline parser: sizing constants,
// byte class, grammar, role and status codes, state and result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clpp_pkg;

    // Sizing
    localparam int MAX_STAGES = 16;
    localparam int MAX_WORDS  = 64;
    localparam int STAGE_W    = $clog2(MAX_STAGES);
    localparam int WORDS_W    = $clog2(MAX_WORDS + 1);

    // Fixed field widths of the result item and the parser state
    localparam int CLASS_W  = 3;
    localparam int ROLE_W   = 2;
    localparam int SIDX_W   = 4;
    localparam int WIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int GS_W     = 3;

    // Special bytes
    localparam logic [7:0] CH_TERM  = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;

    // Byte classes
    localparam logic [CLASS_W-1:0] CL_SPACE = 3'd0;
    localparam logic [CLASS_W-1:0] CL_WORD  = 3'd1;
    localparam logic [CLASS_W-1:0] CL_PIPE  = 3'd2;
    localparam logic [CLASS_W-1:0] CL_RDIN  = 3'd3;
    localparam logic [CLASS_W-1:0] CL_RDOUT = 3'd4;
    localparam logic [CLASS_W-1:0] CL_BG    = 3'd5;
    localparam logic [CLASS_W-1:0] CL_TERM  = 3'd6;

    // Grammar states
    localparam logic [GS_W-1:0] GS_CMD    = 3'd0;
    localparam logic [GS_W-1:0] GS_ACCEPT = 3'd1;
    localparam logic [GS_W-1:0] GS_IN     = 3'd2;
    localparam logic [GS_W-1:0] GS_OUT    = 3'd3;
    localparam logic [GS_W-1:0] GS_BG     = 3'd4;

    // Word roles
    localparam logic [ROLE_W-1:0] ROLE_NONE = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_CMD  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_IN   = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_OUT  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RDIN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RDOUT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WORD_AFTER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd6;

    typedef struct packed {
        logic [GS_W-1:0]     grammar_state;
        logic                inside_word;
        logic [STAGE_W-1:0]  current_stage;
        logic [WORDS_W-1:0]  words_in_stage;
        logic [ROLE_W-1:0]   current_role;
        logic                output_redirected;
        logic                background_seen;
        logic [STATUS_W-1:0] first_error;
    } parse_state_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  char_class;
        logic                word_start;
        logic [ROLE_W-1:0]   word_role;
        logic [SIDX_W-1:0]   stage_index;
        logic [WIDX_W-1:0]   word_index;
        logic                line_done;
        logic [STATUS_W-1:0] status;
        logic                run_in_background;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        grammar_state:     GS_CMD,
        inside_word:       1'b0,
        current_stage:     '0,
        words_in_stage:    '0,
        current_role:      ROLE_NONE,
        output_redirected: 1'b0,
        background_seen:   1'b0,
        first_error:       ST_OK
    };

endpackage

`default_nettype wire

// ===== hw/rtl/clpp_step.sv =====
// One parse step: classify a byte and compute the next parser state and
// the result item for it. Purely combinational. Depends on clpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clpp_step (
    input  wire logic [7:0]            char_code,
    input  wire clpp_pkg::parse_state_t cur,
    output clpp_pkg::parse_state_t     nxt,
    output clpp_pkg::parse_result_t    res
);
    import clpp_pkg::*;

    logic [CLASS_W-1:0] cls;

    // Classify the byte
    always_comb begin
        priority if (char_code == CH_TERM) begin
            cls = CL_TERM;
        end else if (char_code == CH_SPACE ||
                     (char_code >= CH_TAB && char_code <= CH_CR)) begin
            cls = CL_SPACE;
        end else if (char_code == CH_PIPE) begin
            cls = CL_PIPE;
        end else if (char_code == CH_LT) begin
            cls = CL_RDIN;
        end else if (char_code == CH_GT) begin
            cls = CL_RDOUT;
        end else if (char_code == CH_AMP) begin
            cls = CL_BG;
        end else begin
            cls = CL_WORD;
        end
    end

    // Advance the grammar and build the result
    always_comb begin
        nxt                   = cur;
        res.char_class        = cls;
        res.word_start        = 1'b0;
        res.word_role         = ROLE_NONE;
        res.stage_index       = SIDX_W'(cur.current_stage);
        res.word_index        = '0;
        res.line_done         = 1'b0;
        res.status            = cur.first_error;
        res.run_in_background = cur.background_seen;

        if (cls == CL_TERM) begin
            // Report final status, then clear everything
            res.line_done = 1'b1;
            if (cur.first_error == ST_OK && cur.grammar_state != GS_ACCEPT &&
                cur.grammar_state != GS_BG) begin
                res.status = ST_INCOMPLETE;
            end
            nxt = STATE_RESET;
        end else if (cur.first_error == ST_OK) begin
            if (cls == CL_SPACE) begin
                nxt.inside_word = 1'b0;
            end else if (cls == CL_WORD) begin
                priority if (cur.inside_word) begin
                    res.word_role = cur.current_role;
                    if (cur.current_role == ROLE_CMD && cur.words_in_stage != '0) begin
                        res.word_index = WIDX_W'(cur.words_in_stage - WORDS_W'(1));
                    end
                end else if (cur.grammar_state == GS_BG) begin
                    nxt.first_error = ST_WORD_AFTER;
                end else if (cur.grammar_state == GS_IN || cur.grammar_state == GS_OUT) begin
                    res.word_role      = (cur.grammar_state == GS_IN) ? ROLE_IN : ROLE_OUT;
                    res.word_start     = 1'b1;
                    nxt.inside_word    = 1'b1;
                    nxt.current_role   = res.word_role;
                    nxt.grammar_state  = GS_ACCEPT;
                end else if (cur.words_in_stage >= WORDS_W'(MAX_WORDS)) begin
                    nxt.first_error = ST_OVERFLOW;
                end else begin
                    res.word_role      = ROLE_CMD;
                    res.word_start     = 1'b1;
                    res.word_index     = WIDX_W'(cur.words_in_stage);
                    nxt.words_in_stage = cur.words_in_stage + WORDS_W'(1);
                    nxt.inside_word    = 1'b1;
                    nxt.current_role   = ROLE_CMD;
                    nxt.grammar_state  = GS_ACCEPT;
                end
            end else begin
                // Special byte: only legal right after a word
                nxt.inside_word = 1'b0;
                if (cur.grammar_state != GS_ACCEPT) begin
                    nxt.first_error = ST_UNEXPECTED;
                end else begin
                    unique case (cls)
                        CL_PIPE: begin
                            priority if (cur.output_redirected) begin
                                nxt.first_error = ST_BAD_RDOUT;
                            end else if (cur.current_stage ==
                                         STAGE_W'(MAX_STAGES - 1)) begin
                                nxt.first_error = ST_OVERFLOW;
                            end else begin
                                nxt.current_stage  = cur.current_stage + STAGE_W'(1);
                                nxt.words_in_stage = '0;
                                nxt.grammar_state  = GS_CMD;
                            end
                        end
                        CL_RDIN: begin
                            if (cur.current_stage != '0) begin
                                nxt.first_error = ST_BAD_RDIN;
                            end else begin
                                nxt.grammar_state = GS_IN;
                            end
                        end
                        CL_RDOUT: begin
                            nxt.output_redirected = 1'b1;
                            nxt.grammar_state     = GS_OUT;
                        end
                        default: begin
                            nxt.background_seen = 1'b1;
                            nxt.grammar_state   = GS_BG;
                        end
                    endcase
                end
            end
            res.status            = nxt.first_error;
            res.run_in_background = nxt.background_seen;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/command_line_pipeline_parser_top.sv =====
// Command line pipeline parser, top level: parser state register, step
// logic, and an output register with a skid stage. Depends on clpp_pkg, clpp_step.
// A result is registered in the output register, or in the skid stage while the output is held.
// Throughput: one byte per cycle while s_ready is high; the state update is one compare and
// counter step, and the skid stage keeps input ready while one result waits, not while it holds one.
// Reset (aresetn low, synchronous): parser state cleared, no result pending.
// The terminator byte also returns the parser to its reset state.
`timescale 1ns / 1ps
`default_nettype none

module command_line_pipeline_parser_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_char_class,
    output logic            m_word_start,
    output logic [1:0]      m_word_role,
    output logic [3:0]      m_stage_index,
    output logic [5:0]      m_word_index,
    output logic            m_line_done,
    output logic [2:0]      m_status,
    output logic            m_run_in_background
);
    import clpp_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    parse_result_t out_reg;
    parse_result_t skid_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic          s_fire;
    logic          m_fire;

    clpp_step u_step (
        .char_code (s_char_code),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    assign s_ready = ~skid_valid_reg;
    assign s_fire  = s_valid & s_ready;
    assign m_fire  = out_valid_reg & m_ready;

    // Advance parser state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Output register and skid stage: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_fire) begin
                out_valid_reg  <= skid_valid_reg | s_fire;
                skid_valid_reg <= 1'b0;
            end else if (s_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Output register and skid stage: payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_fire) begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        if (s_fire && out_valid_reg && !m_fire) begin
            skid_reg <= step_res;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_char_class        = out_reg.char_class;
    assign m_word_start        = out_reg.word_start;
    assign m_word_role         = out_reg.word_role;
    assign m_stage_index       = out_reg.stage_index;
    assign m_word_index        = out_reg.word_index;
    assign m_line_done         = out_reg.line_done;
    assign m_status            = out_reg.status;
    assign m_run_in_background = out_reg.run_in_background;

endmodule

`default_nettype wire

// ===== verif/command_line_parse_checker.sv =====
// Checker for the command line pipeline parser: watches both channels, predicts
// one result per accepted byte and compares it field by field, in order.
// Depends on clpp_pkg for sizes, byte, class, grammar, role and status codes.
`timescale 1ns / 1ps

module command_line_parse_checker
    import clpp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_char_class,
    input  logic       m_word_start,
    input  logic [1:0] m_word_role,
    input  logic [3:0] m_stage_index,
    input  logic [5:0] m_word_index,
    input  logic       m_line_done,
    input  logic [2:0] m_status,
    input  logic       m_run_in_background,
    output int         mismatch_count,
    output int         pending_results,
    output int         results_checked,
    output int         lines_checked,
    output logic [7:0] status_seen
);

    parse_state_t  parser;
    parse_result_t expected_results[$];

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
        results_checked = 0;
        lines_checked   = 0;
        status_seen     = '0;
        parser          = STATE_RESET;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] c);
        if (c == CH_TERM) return CL_TERM;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CL_SPACE;
        if (c == CH_PIPE) return CL_PIPE;
        if (c == CH_LT) return CL_RDIN;
        if (c == CH_GT) return CL_RDOUT;
        if (c == CH_AMP) return CL_BG;
        return CL_WORD;
    endfunction

    // Advance the parser by one byte and return the result it produces
    function automatic parse_result_t parse_byte(input logic [7:0] c);
        parse_result_t      r;
        logic [CLASS_W-1:0] cls;
        cls = byte_class(c);
        r = '0;
        r.char_class  = cls;
        r.stage_index = parser.current_stage;

        // Terminator: report the final status, then clear everything
        if (cls == CL_TERM) begin
            r.line_done = 1'b1;
            r.status    = parser.first_error;
            if (r.status == ST_OK && parser.grammar_state != GS_ACCEPT &&
                parser.grammar_state != GS_BG) begin
                r.status = ST_INCOMPLETE;
            end
            r.run_in_background = parser.background_seen;
            parser = STATE_RESET;
            return r;
        end

        // After an error everything but the error itself stays frozen
        if (parser.first_error == ST_OK) begin
            if (cls == CL_SPACE) begin
                parser.inside_word = 1'b0;
            end else if (cls == CL_WORD) begin
                if (parser.inside_word) begin
                    r.word_role = parser.current_role;
                    if (parser.current_role == ROLE_CMD && parser.words_in_stage != 0) begin
                        r.word_index = WIDX_W'(parser.words_in_stage - 1'b1);
                    end
                end else if (parser.grammar_state == GS_BG) begin
                    parser.first_error = ST_WORD_AFTER;
                end else if (parser.grammar_state == GS_IN || parser.grammar_state == GS_OUT) begin
                    r.word_role  = (parser.grammar_state == GS_IN) ? ROLE_IN : ROLE_OUT;
                    r.word_start = 1'b1;
                    parser.inside_word   = 1'b1;
                    parser.current_role  = r.word_role;
                    parser.grammar_state = GS_ACCEPT;
                end else if (parser.words_in_stage >= MAX_WORDS) begin
                    parser.first_error = ST_OVERFLOW;
                end else begin
                    r.word_role  = ROLE_CMD;
                    r.word_start = 1'b1;
                    r.word_index = WIDX_W'(parser.words_in_stage);
                    parser.words_in_stage = parser.words_in_stage + 1'b1;
                    parser.inside_word    = 1'b1;
                    parser.current_role   = ROLE_CMD;
                    parser.grammar_state  = GS_ACCEPT;
                end
            end else begin
                // Special bytes are legal only right after a word
                parser.inside_word = 1'b0;
                if (parser.grammar_state != GS_ACCEPT) begin
                    parser.first_error = ST_UNEXPECTED;
                end else if (cls == CL_PIPE) begin
                    if (parser.output_redirected) begin
                        parser.first_error = ST_BAD_RDOUT;
                    end else if (int'(parser.current_stage) + 1 >= MAX_STAGES) begin
                        parser.first_error = ST_OVERFLOW;
                    end else begin
                        parser.current_stage  = parser.current_stage + 1'b1;
                        parser.words_in_stage = '0;
                        parser.grammar_state  = GS_CMD;
                    end
                end else if (cls == CL_RDIN) begin
                    if (parser.current_stage != 0) begin
                        parser.first_error = ST_BAD_RDIN;
                    end else begin
                        parser.grammar_state = GS_IN;
                    end
                end else if (cls == CL_RDOUT) begin
                    parser.output_redirected = 1'b1;
                    parser.grammar_state     = GS_OUT;
                end else begin
                    parser.background_seen = 1'b1;
                    parser.grammar_state   = GS_BG;
                end
            end
        end

        r.status            = parser.first_error;
        r.run_in_background = parser.background_seen;
        return r;
    endfunction

    // Compare results against the oldest prediction, then predict new bytes
    always @(posedge aclk) begin : monitor
        parse_result_t got;
        parse_result_t want;
        if (!aresetn) begin
            parser = STATE_RESET;
            expected_results.delete();
        end else begin
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got = '{char_class: m_char_class, word_start: m_word_start,
                        word_role: m_word_role, stage_index: m_stage_index,
                        word_index: m_word_index, line_done: m_line_done,
                        status: m_status, run_in_background: m_run_in_background};
                if (expected_results.size() == 0) begin
                    report_mismatch("result count, nothing pending", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.char_class !== want.char_class)
                        report_mismatch("char_class", got.char_class, want.char_class);
                    if (got.word_start !== want.word_start)
                        report_mismatch("word_start", got.word_start, want.word_start);
                    if (got.word_role !== want.word_role)
                        report_mismatch("word_role", got.word_role, want.word_role);
                    if (got.stage_index !== want.stage_index)
                        report_mismatch("stage_index", got.stage_index, want.stage_index);
                    if (got.word_index !== want.word_index)
                        report_mismatch("word_index", got.word_index, want.word_index);
                    if (got.line_done !== want.line_done)
                        report_mismatch("line_done", got.line_done, want.line_done);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.run_in_background !== want.run_in_background)
                        report_mismatch("run_in_background", got.run_in_background,
                                        want.run_in_background);
                    if (want.line_done) begin
                        lines_checked++;
                        status_seen[want.status] = 1'b1;
                    end
                end
            end
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                expected_results.push_back(parse_byte(s_char_code));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// ===== verif/command_line_pipeline_parser_top_test.sv =====
// Testbench top for the command line pipeline parser: clock, reset, byte
// stimulus and receiver backpressure, verdict. Depends on clpp_pkg, the parser
// top level and command_line_parse_checker.
`timescale 1ns / 1ps

module command_line_pipeline_parser_top_test;
    import clpp_pkg::*;

    localparam int TARGET_BYTES = 600;
    localparam int HOLD_CYCLES  = 60;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_char_class;
    logic       m_word_start;
    logic [1:0] m_word_role;
    logic [3:0] m_stage_index;
    logic [5:0] m_word_index;
    logic       m_line_done;
    logic [2:0] m_status;
    logic       m_run_in_background;

    int         mismatch_count;
    int         pending_results;
    int         results_checked;
    int         lines_checked;
    logic [7:0] status_seen;

    int         phase        = 0;
    int         tx_idle_pct  = 21;
    int         rx_stall_pct = 58;
    int         bytes_sent   = 0;
    int         lines_sent   = 0;
    logic [7:0] line_chars[$];

    command_line_pipeline_parser_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_code        (s_char_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_char_class       (m_char_class),
        .m_word_start       (m_word_start),
        .m_word_role        (m_word_role),
        .m_stage_index      (m_stage_index),
        .m_word_index       (m_word_index),
        .m_line_done        (m_line_done),
        .m_status           (m_status),
        .m_run_in_background(m_run_in_background)
    );

    command_line_parse_checker u_parse_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_code        (s_char_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_char_class       (m_char_class),
        .m_word_start       (m_word_start),
        .m_word_role        (m_word_role),
        .m_stage_index      (m_stage_index),
        .m_word_index       (m_word_index),
        .m_line_done        (m_line_done),
        .m_status           (m_status),
        .m_run_in_background(m_run_in_background),
        .mismatch_count     (mismatch_count),
        .pending_results    (pending_results),
        .results_checked    (results_checked),
        .lines_checked      (lines_checked),
        .status_seen        (status_seen)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when phases 1 and 2 begin
    initial begin : receiver
        int hold_left;
        int last_phase;
        hold_left  = 0;
        last_phase = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (phase != last_phase) begin
                last_phase = phase;
                if (phase <= 2) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [7:0] random_word_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_PIPE ||
                   c == CH_LT || c == CH_GT || c == CH_AMP);
        return c;
    endfunction

    function automatic logic [7:0] random_special();
        case ($urandom_range(0, 3))
            0: return CH_PIPE;
            1: return CH_LT;
            2: return CH_GT;
            default: return CH_AMP;
        endcase
    endfunction

    // Append a word of the given length
    task automatic push_word(input int len);
        repeat (len) line_chars.push_back(random_word_char());
    endtask

    // Append min..2 whitespace bytes of any kind
    task automatic push_gap(input int min_len);
        int r;
        repeat ($urandom_range(min_len, 2)) begin
            r = $urandom_range(8, 13);
            line_chars.push_back(r == 8 ? CH_SPACE : 8'(r));
        end
    endtask

    // Offer one byte, idling first at random; return once it is accepted
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_chars[i]) send_char(line_chars[i]);
        lines_sent++;
    endtask

    // Build one random line; the terminator is appended here
    task automatic build_random_line(input int kind);
        int n;
        int stages;
        int pos;
        line_chars.delete();
        if (kind <= 3) begin
            // noise: mostly specials and spaces mixed with arbitrary bytes
            n = $urandom_range(1, 12);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0: line_chars.push_back(random_special());
                    1: line_chars.push_back(CH_SPACE);
                    default: line_chars.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end else if (kind <= 5) begin
            // pipeline at and beyond the stage limit
            n = $urandom_range(MAX_STAGES - 2, MAX_STAGES + 1);
            for (int i = 0; i < n; i++) begin
                push_word($urandom_range(1, 2));
                if (i < n - 1) begin
                    push_gap(0);
                    line_chars.push_back(CH_PIPE);
                    push_gap(0);
                end
            end
        end else if (kind == 6) begin
            // one stage at and beyond the word limit
            n = $urandom_range(MAX_WORDS - 2, MAX_WORDS + 2);
            for (int i = 0; i < n; i++) begin
                push_word(1);
                push_gap(1);
            end
        end else begin
            // well-formed pipeline with random content
            stages = $urandom_range(1, 4);
            for (int s = 0; s < stages; s++) begin
                if (s > 0) begin
                    push_gap(0);
                    line_chars.push_back(CH_PIPE);
                    push_gap(0);
                end
                n = $urandom_range(1, 3);
                for (int w = 0; w < n; w++) begin
                    if (w > 0) push_gap(1);
                    push_word($urandom_range(1, 4));
                end
                if (s == 0 && $urandom_range(0, 2) == 0) begin
                    push_gap(0);
                    line_chars.push_back(CH_LT);
                    push_gap(0);
                    push_word($urandom_range(1, 3));
                end
                if (s == stages - 1 && $urandom_range(0, 2) == 0) begin
                    push_gap(0);
                    line_chars.push_back(CH_GT);
                    push_gap(0);
                    push_word($urandom_range(1, 3));
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                push_gap(0);
                line_chars.push_back(CH_AMP);
            end
            if ($urandom_range(0, 3) == 0) push_gap(1);
            // corrupt a fifth of them with a stray byte
            if ($urandom_range(0, 4) == 0) begin
                pos = $urandom_range(0, line_chars.size() - 1);
                line_chars[pos] = $urandom_range(0, 1) ? random_special() : random_word_char();
            end
        end
        line_chars.push_back(CH_TERM);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        string directed_lines[6];
        int    line_count;
        directed_lines = '{"", "\377<b>c& ", "|", "a|b<", "a>b|", "x&\ty"};
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_char_code <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        phase = 1;

        // Directed lines: empty, all operators, each grammar error
        foreach (directed_lines[i]) begin
            line_chars.delete();
            for (int k = 0; k < directed_lines[i].len(); k++) begin
                line_chars.push_back(directed_lines[i][k]);
            end
            line_chars.push_back(CH_TERM);
            send_line();
        end

        // Random lines; the first two hit the stage and word limits
        line_count = 0;
        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent >= 400) begin
                phase        = 3;
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end else if (bytes_sent >= 200) begin
                phase        = 2;
                tx_idle_pct  = 58;
                rx_stall_pct = 21;
            end
            if (line_count == 0) build_random_line(4);
            else if (line_count == 1) build_random_line(6);
            else build_random_line($urandom_range(0, 39));
            send_line();
            line_count++;
        end
        s_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d bytes in %0d lines, %0d results compared, %0d lines ended.",
                 bytes_sent, lines_sent, results_checked, lines_checked);
        $display("Final status codes reached (one bit per code): %b", status_seen);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
